// ----- hw/rtl/gtlfb_pkg.sv -----
`timescale 1ns / 1ps

package gtlfb_pkg;

    localparam logic [1:0] OP_BUS_BYTE  = 2'd0;
    localparam logic [1:0] OP_HOST_BYTE = 2'd1;
    localparam logic [1:0] OP_TICK      = 2'd2;

    localparam logic [7:0]  STATUS_BYTE   = 8'h10;
    localparam logic [3:0]  LEN_MASK_BITS = 4'hF;
    localparam logic [15:0] IDLE_MAX      = 16'hFFFF;
    localparam logic [15:0] GAP_RESET     = 16'd520;

    localparam logic [2:0] ADDR_GAP_TICKS = 3'd0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_BUS_LEN,
        ST_BUS_DATA,
        ST_STATUS,
        ST_HOST_DATA
    } state_t;

    typedef enum logic [1:0] {
        SEL_BUS_LEN,
        SEL_BUS_DATA,
        SEL_STATUS,
        SEL_HOST_DATA
    } emit_sel_t;

    typedef struct packed {
        logic      accept;
        logic      load;
        emit_sel_t sel;
        logic      idx_clear;
        logic      idx_inc;
    } cmd_t;

    typedef struct packed {
        logic bus_status;
        logic bus_send;
        logic host_send;
        logic idx_last;
        logic out_free;
    } status_t;

endpackage

// ----- hw/rtl/gtlfb_ctrl.sv -----
`timescale 1ns / 1ps

module gtlfb_ctrl
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  gtlfb_pkg::status_t status,
    output gtlfb_pkg::cmd_t    cmd
);
    import gtlfb_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        in_ready      = 1'b0;
        cmd.accept    = 1'b0;
        cmd.load      = 1'b0;
        cmd.sel       = SEL_BUS_LEN;
        cmd.idx_clear = 1'b0;
        cmd.idx_inc   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.accept    = 1'b1;
                    cmd.idx_clear = 1'b1;
                    if (status.bus_status)
                    begin
                        state_next = ST_STATUS;
                    end
                    else if (status.bus_send)
                    begin
                        state_next = ST_BUS_LEN;
                    end
                    else if (status.host_send)
                    begin
                        state_next = ST_HOST_DATA;
                    end
                end
            end
            ST_BUS_LEN:
            begin
                cmd.sel = SEL_BUS_LEN;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_BUS_DATA;
                end
            end
            ST_BUS_DATA:
            begin
                cmd.sel = SEL_BUS_DATA;
                if (status.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_STATUS:
            begin
                cmd.sel = SEL_STATUS;
                if (status.out_free)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_HOST_DATA:
            begin
                cmd.sel = SEL_HOST_DATA;
                if (status.out_free)
                begin
                    cmd.load    = 1'b1;
                    cmd.idx_inc = 1'b1;
                    if (status.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- hw/rtl/gtlfb_datapath.sv -----
`timescale 1ns / 1ps

module gtlfb_datapath
#(
    parameter int MAX_FRAME = 4
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic [15:0]        gap_ticks,
    input  logic [1:0]         in_operation,
    input  logic [7:0]         in_data,
    input  logic               in_mark,
    input  gtlfb_pkg::cmd_t    cmd,
    output gtlfb_pkg::status_t status,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               out_port,
    output logic [7:0]         out_byte,
    output logic               out_mark,
    output logic               out_last
);
    import gtlfb_pkg::*;

    localparam int LW = $clog2(MAX_FRAME + 1);
    localparam int IW = (MAX_FRAME > 1) ? $clog2(MAX_FRAME) : 1;
    localparam logic [LW-1:0] MAX_LEN = LW'(MAX_FRAME);
    localparam logic [3:0]    MAX_NIB = 4'(MAX_FRAME);

    logic [7:0]    bus_buf [MAX_FRAME];
    logic [7:0]    host_buf [MAX_FRAME];

    logic [LW-1:0] bus_count_reg;
    logic [LW-1:0] bus_count_next;
    logic          bus_zero_reg;
    logic          bus_zero_next;
    logic [15:0]   idle_reg;
    logic [15:0]   idle_next;
    logic          armed_reg;
    logic          armed_next;
    logic [LW-1:0] host_exp_reg;
    logic [LW-1:0] host_exp_next;
    logic [LW-1:0] host_pos_reg;
    logic [LW-1:0] host_pos_next;
    logic          host_open_reg;
    logic          host_open_next;
    logic [LW-1:0] em_len_reg;
    logic [LW-1:0] em_len_next;
    logic [IW-1:0] idx_reg;

    logic          out_valid_reg;
    logic          out_port_reg;
    logic [7:0]    out_byte_reg;
    logic          out_mark_reg;
    logic          out_last_reg;

    logic          bus_wr;
    logic          host_wr;
    logic [IW-1:0] host_wr_idx;
    logic [7:0]    host_wr_data;
    logic [15:0]   idle_inc;
    logic [3:0]    len_nib;
    logic [LW-1:0] hdr_len;

    logic          sel_port;
    logic [7:0]    sel_byte;
    logic          sel_mark;
    logic          sel_last;

    always_comb
    begin
        bus_count_next   = bus_count_reg;
        bus_zero_next    = bus_zero_reg;
        idle_next        = idle_reg;
        armed_next       = armed_reg;
        host_exp_next    = host_exp_reg;
        host_pos_next    = host_pos_reg;
        host_open_next   = host_open_reg;
        em_len_next      = em_len_reg;
        bus_wr           = 1'b0;
        host_wr          = 1'b0;
        host_wr_idx      = host_pos_reg[IW-1:0];
        host_wr_data     = in_data;
        status.bus_status = 1'b0;
        status.bus_send   = 1'b0;
        status.host_send  = 1'b0;
        status.idx_last   = ((LW'(idx_reg) + LW'(1)) == em_len_reg);
        status.out_free   = !out_valid_reg || out_ready;
        idle_inc = (idle_reg == IDLE_MAX) ? idle_reg : idle_reg + 16'd1;
        len_nib  = in_data[3:0] & LEN_MASK_BITS;
        hdr_len  = (len_nib > MAX_NIB) ? MAX_LEN : LW'(len_nib);
        case (in_operation)
            OP_BUS_BYTE:
            begin
                if (bus_count_reg < MAX_LEN)
                begin
                    bus_wr         = 1'b1;
                    bus_count_next = bus_count_reg + LW'(1);
                    if (bus_count_reg == '0)
                    begin
                        bus_zero_next = (in_data == 8'h00);
                    end
                end
                idle_next  = '0;
                armed_next = 1'b1;
            end
            OP_HOST_BYTE:
            begin
                if (in_mark)
                begin
                    host_exp_next = hdr_len;
                    host_pos_next = '0;
                    if (hdr_len == '0)
                    begin
                        host_wr          = 1'b1;
                        host_wr_idx      = '0;
                        host_open_next   = 1'b0;
                        em_len_next      = LW'(1);
                        status.host_send = 1'b1;
                    end
                    else
                    begin
                        host_open_next = 1'b1;
                    end
                end
                else if (host_open_reg && (host_pos_reg < host_exp_reg))
                begin
                    host_wr       = 1'b1;
                    host_pos_next = host_pos_reg + LW'(1);
                    if (host_pos_reg + LW'(1) == host_exp_reg)
                    begin
                        host_open_next   = 1'b0;
                        em_len_next      = host_exp_reg;
                        status.host_send = 1'b1;
                    end
                end
            end
            OP_TICK:
            begin
                if (armed_reg)
                begin
                    idle_next = idle_inc;
                    if (idle_inc >= gap_ticks)
                    begin
                        armed_next     = 1'b0;
                        idle_next      = '0;
                        bus_count_next = '0;
                        em_len_next    = bus_count_reg;
                        if ((bus_count_reg == LW'(1)) && bus_zero_reg)
                        begin
                            status.bus_status = 1'b1;
                        end
                        else if (bus_count_reg != '0)
                        begin
                            status.bus_send = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bus_count_reg <= '0;
            bus_zero_reg  <= 1'b0;
            idle_reg      <= '0;
            armed_reg     <= 1'b0;
            host_exp_reg  <= '0;
            host_pos_reg  <= '0;
            host_open_reg <= 1'b0;
            em_len_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                bus_count_reg <= bus_count_next;
                bus_zero_reg  <= bus_zero_next;
                idle_reg      <= idle_next;
                armed_reg     <= armed_next;
                host_exp_reg  <= host_exp_next;
                host_pos_reg  <= host_pos_next;
                host_open_reg <= host_open_next;
                em_len_reg    <= em_len_next;
            end
            if (cmd.idx_clear)
            begin
                idx_reg <= '0;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_reg + IW'(1);
            end
            if (cmd.load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && bus_wr)
        begin
            bus_buf[bus_count_reg[IW-1:0]] <= in_data;
        end
        if (cmd.accept && host_wr)
        begin
            host_buf[host_wr_idx] <= host_wr_data;
        end
        if (cmd.load)
        begin
            out_port_reg <= sel_port;
            out_byte_reg <= sel_byte;
            out_mark_reg <= sel_mark;
            out_last_reg <= sel_last;
        end
    end

    always_comb
    begin
        sel_port = 1'b0;
        sel_byte = 8'h00;
        sel_mark = 1'b0;
        sel_last = 1'b0;
        case (cmd.sel)
            SEL_BUS_LEN:
            begin
                sel_byte = 8'(em_len_reg);
                sel_mark = 1'b1;
            end
            SEL_BUS_DATA:
            begin
                sel_byte = bus_buf[idx_reg];
                sel_last = status.idx_last;
            end
            SEL_STATUS:
            begin
                sel_byte = STATUS_BYTE;
                sel_mark = 1'b1;
                sel_last = 1'b1;
            end
            SEL_HOST_DATA:
            begin
                sel_port = 1'b1;
                sel_byte = host_buf[idx_reg];
                sel_last = status.idx_last;
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_port  = out_port_reg;
    assign out_byte  = out_byte_reg;
    assign out_mark  = out_mark_reg;
    assign out_last  = out_last_reg;

endmodule

// ----- hw/rtl/gap_to_length_frame_bridge.sv -----
`timescale 1ns / 1ps
// an accepted input moves ctrl to an emit state, which loads the first result byte
// throughput: one input transaction per cycle when it emits nothing; otherwise no new
// input is accepted until all n result bytes (n at most MAX_FRAME + 1) are loaded, and
// each byte waits for the output register to be free
// reset: rst_n async active low, clears frame state and output valid, gap_ticks to 520
module gap_to_length_frame_bridge
#(
    parameter int MAX_FRAME = 4
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // data
    input  logic [2:0]  s_axis_tuser,   // operation[1:0], mark[2]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // out_byte
    output logic [1:0]  m_axis_tuser,   // port[0], out_mark[1]
    output logic        m_axis_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gtlfb_pkg::*;

    logic [15:0] gap_ticks_reg;
    cmd_t        cmd;
    status_t     status;

    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gap_ticks_reg <= GAP_RESET;
        end
        else if (psel && penable && pwrite && pready && (paddr == ADDR_GAP_TICKS))
        begin
            gap_ticks_reg <= pwdata[15:0];
        end
    end

    assign prdata = (paddr == ADDR_GAP_TICKS) ? {16'h0000, gap_ticks_reg} : 32'h0;

    gtlfb_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .status   (status),
        .cmd      (cmd)
    );

    gtlfb_datapath
    #(
        .MAX_FRAME (MAX_FRAME)
    )
    u_datapath
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .gap_ticks    (gap_ticks_reg),
        .in_operation (s_axis_tuser[1:0]),
        .in_data      (s_axis_tdata),
        .in_mark      (s_axis_tuser[2]),
        .cmd          (cmd),
        .status       (status),
        .out_valid    (m_axis_tvalid),
        .out_ready    (m_axis_tready),
        .out_port     (m_axis_tuser[0]),
        .out_byte     (m_axis_tdata),
        .out_mark     (m_axis_tuser[1]),
        .out_last     (m_axis_tlast)
    );

endmodule
